// ===== rtl/pcop_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the circle plotter.
package pcop_pkg;

	localparam int RADIUS_BITS  = 12;
	localparam int COORD_BITS   = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int PIX_BITS     = 18;
	localparam int ITER_BITS    = 5;
	localparam int XY_BITS      = 34;
	localparam int Z_BITS       = 35;
	localparam int QUO_BITS     = 31;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Gain-compensated start value of the CORDIC x register, 0.60725 in Q4.30.
	localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(34'sh026DD3B6A);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CORDIC,
		ST_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		CP_IDLE,
		CP_ITER,
		CP_MULA,
		CP_MULB
	} cordic_phase_t;

	// Arctangent of 2^-i in Q2.30, truncated.
	function automatic logic [31:0] atan_q30(input logic [ITER_BITS-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/pcop_ifs.sv =====
// Request and pixel channel interfaces of the circle plotter.
interface pcop_in_if;
	import pcop_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [RADIUS_BITS-1:0] radius;
	modport source(output valid, command, center_x, center_y, radius, input ready);
	modport sink(input valid, command, center_x, center_y, radius, output ready);
endinterface

interface pcop_out_if;
	import pcop_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [PIX_BITS-1:0] pixel_x;
	logic signed [PIX_BITS-1:0] pixel_y;
	logic                       last;
	logic                       done_res;
	modport source(output valid, pixel_x, pixel_y, last, done_res, input ready);
	modport sink(input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

// ===== rtl/polar_circle_octant_plotter.sv =====
// A start runs the serial divider, a step runs the CORDIC rotation and the pixel scaling.
// Each request then delivers eight pixels at one per cycle, as long as out_ch.ready holds.
// A request is taken only in the idle state, so a new one waits until all eight pixels
// of the one before are loaded; a step while no circle is active stays idle and yields nothing.
// The asynchronous reset clears the control state and leaves the plotter idle.
module polar_circle_octant_plotter (
	input  logic          clk,
	input  logic          arst_n,
	pcop_in_if.sink       in_ch,
	pcop_out_if.source    out_ch
);
	import pcop_pkg::*;

	top_state_t                 state_q, state_d;
	logic                       active_q;
	logic [COORD_BITS-1:0]      cx_q, cy_q;
	logic [RADIUS_BITS-1:0]     r_q;
	logic [31:0]                angle_q, step_q, angle_nx;
	logic signed [PIX_BITS-1:0] a_q, b_q;
	logic                       done_q;
	logic [2:0]                 k_q;
	logic                       ov_q, last_q, odone_q;
	logic signed [PIX_BITS-1:0] ox_q, oy_q;
	logic                       accept, div_start, div_done, cor_start, cor_done;
	logic                       load_px;
	logic [QUO_BITS-1:0]        quo;
	logic signed [PIX_BITS-1:0] cor_a, cor_b;
	logic signed [PIX_BITS-1:0] cxs, cys, xo, yo, px, py;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign angle_nx  = angle_q + step_q;
	assign div_start = accept && in_ch.command == CMD_START && in_ch.radius != '0;
	assign cor_start = accept && in_ch.command == CMD_STEP && active_q;
	assign load_px   = (state_q == ST_EMIT) && (!ov_q || out_ch.ready);

	pcop_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.radius   (in_ch.radius),
		.done     (div_done),
		.quotient (quo)
	);

	pcop_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (angle_nx),
		.radius (r_q),
		.done   (cor_done),
		.a      (cor_a),
		.b      (cor_b)
	);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_ch.command == CMD_START)
						state_d = (in_ch.radius == '0) ? ST_EMIT : ST_DIV;
					else if (active_q)
						state_d = ST_CORDIC;
				end
			end
			ST_DIV:    if (div_done) state_d = ST_EMIT;
			ST_CORDIC: if (cor_done) state_d = ST_EMIT;
			ST_EMIT:   if (load_px && k_q == 3'd7) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			angle_q  <= '0;
			step_q   <= '0;
			k_q      <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_ch.command == CMD_START) begin
				cx_q     <= in_ch.center_x;
				cy_q     <= in_ch.center_y;
				r_q      <= in_ch.radius;
				angle_q  <= '0;
				step_q   <= '0;
				active_q <= (in_ch.radius != '0);
			end
			if (cor_start)
				angle_q <= angle_nx;
			if (state_q == ST_DIV && div_done)
				step_q <= 32'(quo);
			if (state_q == ST_CORDIC && cor_done && cor_a <= cor_b)
				active_q <= 1'b0;
			// Output register handshake.
			if (load_px) begin
				ov_q <= 1'b1;
				k_q  <= k_q + 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Octant offsets and completion flag of the group to emit.
	always_ff @(posedge clk) begin
		if (accept && in_ch.command == CMD_START) begin
			a_q    <= PIX_BITS'(in_ch.radius);
			b_q    <= '0;
			done_q <= (in_ch.radius == '0);
		end
		if (state_q == ST_CORDIC && cor_done) begin
			a_q    <= cor_a;
			b_q    <= cor_b;
			done_q <= (cor_a <= cor_b);
		end
	end

	// Mirror the offsets into the eight octants in the fixed emit order.
	assign cxs = PIX_BITS'(cx_q);
	assign cys = PIX_BITS'(cy_q);
	assign xo  = k_q[0] ? b_q : a_q;
	assign yo  = k_q[0] ? a_q : b_q;
	assign px  = (k_q >= 3'd2 && k_q <= 3'd5) ? cxs - xo : cxs + xo;
	assign py  = (k_q <= 3'd3) ? cys - yo : cys + yo;

	always_ff @(posedge clk) begin
		if (load_px) begin
			ox_q    <= px;
			oy_q    <= py;
			last_q  <= (k_q == 3'd7);
			odone_q <= done_q;
		end
	end

	assign out_ch.valid    = ov_q;
	assign out_ch.pixel_x  = ox_q;
	assign out_ch.pixel_y  = oy_q;
	assign out_ch.last     = last_q;
	assign out_ch.done_res = odone_q;

	// A step with no circle in progress goes straight back to idle.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.command == CMD_STEP && !active_q |=> state_q == ST_IDLE)
		else $error("idle step did not return to idle");

	// While a finishing group is being emitted the circle is no longer active.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && done_q |-> !active_q)
		else $error("circle still active on a finishing group");

	// The group counter is back at zero whenever a request can be taken.
	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> k_q == 3'd0)
		else $error("pixel counter not at group start in idle");

endmodule

// ===== rtl/pcop_div.sv =====
// Bit-serial restoring divider that forms the angle step round(2^30 / R).
module pcop_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pcop_pkg::RADIUS_BITS-1:0]  radius,
	output logic                              done,
	output logic [pcop_pkg::QUO_BITS-1:0]     quotient
);
	import pcop_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [ITER_BITS-1:0]   bit_q;
	logic [QUO_BITS-1:0]    num_q;
	logic [QUO_BITS-1:0]    quo_q;
	logic [RADIUS_BITS-1:0] div_q;
	logic [RADIUS_BITS:0]   rem_q;
	logic [RADIUS_BITS:0]   trial;
	logic                   fits;

	// One quotient bit per cycle: shift in the next numerator bit and try a subtract.
	assign trial = {rem_q[RADIUS_BITS-1:0], num_q[bit_q]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: the numerator is 2^30 plus half the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= QUO_BITS'(1) << 30 | QUO_BITS'(radius >> 1);
			div_q <= radius;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= ITER_BITS'(QUO_BITS - 1);
		end else if (busy_q) begin
			rem_q        <= fits ? trial - {1'b0, div_q} : trial;
			quo_q[bit_q] <= fits;
			bit_q        <= bit_q - 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/pcop_cordic.sv =====
// Iterative rotation-mode CORDIC with a shared multiplier that scales to pixels.
module pcop_cordic (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [31:0]                             angle,
	input  logic [pcop_pkg::RADIUS_BITS-1:0]        radius,
	output logic                                    done,
	output logic signed [pcop_pkg::PIX_BITS-1:0]    a,
	output logic signed [pcop_pkg::PIX_BITS-1:0]    b
);
	import pcop_pkg::*;

	cordic_phase_t               phase_q, phase_d;
	logic                        done_q;
	logic [ITER_BITS-1:0]        i_q;
	logic signed [XY_BITS-1:0]   x_q, y_q, dx, dy, mop;
	logic signed [Z_BITS-1:0]    z_q, at;
	logic [RADIUS_BITS-1:0]      r_q;
	logic signed [RADIUS_BITS+XY_BITS:0] prod, rnd;
	logic signed [PIX_BITS-1:0]  a_q, b_q, pix;

	// Shared shifter and angle table for one micro-rotation.
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = Z_BITS'(atan_q30(i_q));

	// Shared multiplier: radius times cos, then radius times sin, rounded half up.
	assign mop  = (phase_q == CP_MULA) ? x_q : y_q;
	assign prod = $signed({1'b0, r_q}) * mop;
	assign rnd  = prod + ((RADIUS_BITS+XY_BITS+1)'(1) <<< 29);
	assign pix  = PIX_BITS'(rnd >>> 30);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			CP_IDLE: if (start) phase_d = CP_ITER;
			CP_ITER: if (i_q == ITER_BITS'(CORDIC_STEPS - 1)) phase_d = CP_MULA;
			CP_MULA: phase_d = CP_MULB;
			CP_MULB: phase_d = CP_IDLE;
			default: phase_d = CP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CP_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == CP_MULB);
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			CP_IDLE: begin
				if (start) begin
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					z_q <= Z_BITS'({1'b0, angle});
					r_q <= radius;
					i_q <= '0;
				end
			end
			CP_ITER: begin
				if (z_q[Z_BITS-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end
				i_q <= i_q + 1'b1;
			end
			CP_MULA: a_q <= pix;
			CP_MULB: b_q <= pix;
			default: ;
		endcase
	end

	assign done = done_q;
	assign a    = a_q;
	assign b    = b_q;

endmodule
